// ===== rtl/ccsg_pkg.sv =====
// Shared types, constants and lookup tables of the contour cell segment generator.
// No dependencies; used by every module in rtl/ except ccsg_div.
package ccsg_pkg;

    localparam int CFG_W       = 7;
    localparam int COORD_W     = 8;
    localparam int PRES_W      = 15;
    localparam int PT_W        = 17;
    localparam int LEVEL_W     = 11;
    localparam int MAX_RESULTS = 32;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 7'd4;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_BOTTOM = 2'd2;
    localparam logic [1:0] EDGE_LEFT   = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [PRES_W-1:0]  p_top_left;
        logic [PRES_W-1:0]  p_top_right;
        logic [PRES_W-1:0]  p_bottom_right;
        logic [PRES_W-1:0]  p_bottom_left;
    } in_beat_t;

    typedef struct packed {
        logic [PT_W-1:0]    start_x;
        logic [PT_W-1:0]    start_y;
        logic [PT_W-1:0]    end_x;
        logic [PT_W-1:0]    end_y;
        logic [LEVEL_W-1:0] level_hpa;
        logic               truncated;
        logic               last;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic div_k0;
        logic cap_k0;
        logic div_k1;
        logic cap_k1;
        logic setup;
        logic cnt_step;
        logic emit_prep;
        logic lvl_next;
        logic div_pt;
        logic cap_pt;
        logic pt_b;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic empty;
        logic lvl_done;
        logic cnt_zero;
        logic nseg_zero;
        logic seg_more;
        logic last_emit;
        logic out_free;
    } sts_t;

    function automatic logic [1:0] seg_count(input logic [3:0] cs);
        case (cs)
            4'd0, 4'd15: seg_count = 2'd0;
            4'd5, 4'd10: seg_count = 2'd2;
            default:     seg_count = 2'd1;
        endcase
    endfunction

    // idx = {segment, endpoint}
    function automatic logic [1:0] seg_edge(input logic [3:0] cs, input logic [1:0] idx);
        logic [7:0] row;
        unique case (cs)
            4'd1:    row = {EDGE_LEFT,   EDGE_BOTTOM, 4'd0};
            4'd2:    row = {EDGE_BOTTOM, EDGE_RIGHT,  4'd0};
            4'd3:    row = {EDGE_LEFT,   EDGE_RIGHT,  4'd0};
            4'd4:    row = {EDGE_RIGHT,  EDGE_TOP,    4'd0};
            4'd5:    row = {EDGE_TOP, EDGE_LEFT, EDGE_RIGHT, EDGE_BOTTOM};
            4'd6:    row = {EDGE_TOP,    EDGE_BOTTOM, 4'd0};
            4'd7:    row = {EDGE_LEFT,   EDGE_TOP,    4'd0};
            4'd8:    row = {EDGE_TOP,    EDGE_LEFT,   4'd0};
            4'd9:    row = {EDGE_TOP,    EDGE_BOTTOM, 4'd0};
            4'd10:   row = {EDGE_TOP, EDGE_RIGHT, EDGE_BOTTOM, EDGE_LEFT};
            4'd11:   row = {EDGE_TOP,    EDGE_RIGHT,  4'd0};
            4'd12:   row = {EDGE_RIGHT,  EDGE_LEFT,   4'd0};
            4'd13:   row = {EDGE_RIGHT,  EDGE_BOTTOM, 4'd0};
            4'd14:   row = {EDGE_BOTTOM, EDGE_LEFT,   4'd0};
            default: row = 8'd0;
        endcase
        unique case (idx)
            2'd0:    seg_edge = row[7:6];
            2'd1:    seg_edge = row[5:4];
            2'd2:    seg_edge = row[3:2];
            default: seg_edge = row[1:0];
        endcase
    endfunction

endpackage

// ===== rtl/contour_cell_segment_generator_top.sv =====
// Top level: contour interval register, sequencer and datapath.
// Depends on ccsg_pkg, ccsg_ctrl, ccsg_datapath.
//
// One cell at a time, through a single shared one-bit-per-cycle divider.
// A cell passes through:
//   - the accept state;
//   - two range divisions;
//   - a setup state;
//   - a count pass over the L levels in range;
//   - an emission prep state.
// Each emitted segment then adds two endpoint divisions and an output load, plus a
// level step where the segment opens a level, one per level without segments that is
// skipped, and any wait of the output register on m_ready. A cell with no level in
// range is done after the range divisions and the setup state. The finished segment
// sits in an output register, so the next cell is accepted while the final beat of a
// cell is still waiting to be taken.
module contour_cell_segment_generator_top
    import ccsg_pkg::*;
#(
    parameter int MAX_LEVELS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data
);
    logic [CFG_W-1:0] interval_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_we) begin
            interval_reg <= cfg_wdata;
        end
    end

    ccsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ccsg_datapath #(
        .MAX_LEVELS (MAX_LEVELS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .interval (interval_reg),
        .in_data  (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );
endmodule

// ===== rtl/ccsg_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by ccsg_datapath.
module ccsg_div #(
    parameter int NW = 25,
    parameter int DW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;

    always_comb begin
        trial    = {rem_reg, quo_reg[NW-1]};
        quo_next = {quo_reg[NW-2:0], 1'b0};
        rem_next = trial[DW-1:0];
        if (trial >= {1'b0, den_reg}) begin
            rem_next    = DW'(trial - {1'b0, den_reg});
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

// ===== rtl/ccsg_datapath.sv =====
// Datapath: cell registers, level range, case lookup, endpoint interpolation, output beat.
// Depends on ccsg_pkg and ccsg_div.
module ccsg_datapath
    import ccsg_pkg::*;
#(
    parameter int MAX_LEVELS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [CFG_W-1:0] interval,
    input  in_beat_t         in_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data
);
    localparam int NW = FRAC_BITS + 17;
    localparam int DW = 16;
    localparam int LW = $clog2(MAX_LEVELS + 1);
    localparam int CW = $clog2(2 * MAX_LEVELS + 1);
    localparam int KW = 12;
    localparam int XW = COORD_W + FRAC_BITS + 1;
    localparam int TW = FRAC_BITS + 1;
    localparam logic [NW-1:0] ONE_N = NW'(1) << FRAC_BITS;
    localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;

    in_beat_t           cell_reg;
    logic [PRES_W-1:0]  mn_reg, mx_reg;
    logic [KW-1:0]      k0_reg, k1_reg;
    logic [KW-1:0]      level_reg, lev0_reg;
    logic [LW-1:0]      lvl_n_reg, lvl_idx_reg;
    logic [CW-1:0]      count_reg, total_reg, emitted_reg;
    logic               trunc_reg, seg_reg;
    logic [1:0]         edge_reg;
    logic               dz_reg;
    logic [PT_W-1:0]    ax_reg, ay_reg, bx_reg, by_reg;
    logic               m_valid_reg;
    out_beat_t          m_data_reg;

    logic [CFG_W-1:0]   iv;
    logic [10:0]        step16;
    logic [PRES_W-1:0]  mn_a, mn_b, mx_a, mx_b;
    logic [15:0]        lev16;
    logic [3:0]         cs;
    logic [1:0]         nseg;
    logic [KW-1:0]      diff;
    logic               lev_trunc;
    logic [1:0]         edge_sel;
    logic [PRES_W-1:0]  qa, qb, e_n, e_d;
    logic [PRES_W-1:0]  fa, fb;
    logic               div_start;
    logic [NW-1:0]      div_num, quot;
    logic [DW-1:0]      div_den;
    logic               div_done;
    logic [TW-1:0]      t;
    logic [XW-1:0]      bxw, byw, px, py;

    assign iv     = (interval == '0) ? CFG_W'(1) : interval;
    assign step16 = {iv, 4'b0};

    always_comb begin
        mn_a = (in_data.p_top_left < in_data.p_top_right) ? in_data.p_top_left
                                                           : in_data.p_top_right;
        mn_b = (in_data.p_bottom_right < in_data.p_bottom_left) ? in_data.p_bottom_right
                                                                 : in_data.p_bottom_left;
        mx_a = (in_data.p_top_left > in_data.p_top_right) ? in_data.p_top_left
                                                           : in_data.p_top_right;
        mx_b = (in_data.p_bottom_right > in_data.p_bottom_left) ? in_data.p_bottom_right
                                                                 : in_data.p_bottom_left;
    end

    assign lev16 = {level_reg, 4'b0};
    assign cs = {({1'b0, cell_reg.p_top_left}     >= lev16),
                 ({1'b0, cell_reg.p_top_right}    >= lev16),
                 ({1'b0, cell_reg.p_bottom_right} >= lev16),
                 ({1'b0, cell_reg.p_bottom_left}  >= lev16)};
    assign nseg = seg_count(cs);

    assign diff      = k1_reg - k0_reg;
    assign lev_trunc = {1'b0, diff} >= (KW + 1)'(MAX_LEVELS);

    // Edge operands for the endpoint about to be divided
    assign edge_sel = seg_edge(cs, {seg_reg, cmd.pt_b});
    always_comb begin
        case (edge_sel)
            EDGE_TOP:    begin qa = cell_reg.p_top_left;    qb = cell_reg.p_top_right;    end
            EDGE_RIGHT:  begin qa = cell_reg.p_top_right;   qb = cell_reg.p_bottom_right; end
            EDGE_BOTTOM: begin qa = cell_reg.p_bottom_left; qb = cell_reg.p_bottom_right; end
            default:     begin qa = cell_reg.p_top_left;    qb = cell_reg.p_bottom_left;  end
        endcase
        fa  = lev16[PRES_W-1:0];
        fb  = qa;
        e_n = ({1'b0, fb} > lev16) ? PRES_W'(fb - fa) : PRES_W'(lev16 - {1'b0, fb});
        e_d = (qb >= qa) ? qb - qa : qa - qb;
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (cmd.div_k0) begin
            div_start = 1'b1;
            div_num   = NW'({1'b0, mn_reg} + {5'd0, step16} - 16'd1);
            div_den   = DW'(step16);
        end else if (cmd.div_k1) begin
            div_start = 1'b1;
            div_num   = NW'(mx_reg);
            div_den   = DW'(step16);
        end else if (cmd.div_pt) begin
            div_start = 1'b1;
            div_num   = NW'({e_n, {(FRAC_BITS + 1){1'b0}}}) + NW'(e_d);
            div_den   = {e_d, 1'b0};
        end
    end

    ccsg_div #(.NW(NW), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (quot)
    );

    // Interpolated point from the finished division
    always_comb begin
        if (dz_reg)
            t = '0;
        else if (quot > ONE_N)
            t = TW'(ONE_N);
        else
            t = quot[TW-1:0];
        bxw = XW'({cell_reg.cell_x, {FRAC_BITS{1'b0}}});
        byw = XW'({cell_reg.cell_y, {FRAC_BITS{1'b0}}});
        case (edge_reg)
            EDGE_TOP:    begin px = bxw + XW'(t); py = byw;          end
            EDGE_RIGHT:  begin px = bxw + ONE_X;  py = byw + XW'(t); end
            EDGE_BOTTOM: begin px = bxw + XW'(t); py = byw + ONE_X;  end
            default:     begin px = bxw;          py = byw + XW'(t); end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cell_reg <= in_data;
            mn_reg   <= (mn_a < mn_b) ? mn_a : mn_b;
            mx_reg   <= (mx_a > mx_b) ? mx_a : mx_b;
        end
        if (cmd.cap_k0) k0_reg <= quot[KW-1:0];
        if (cmd.cap_k1) k1_reg <= quot[KW-1:0];
        if (cmd.setup) begin
            lev0_reg    <= KW'(k0_reg * iv);
            level_reg   <= KW'(k0_reg * iv);
            trunc_reg   <= lev_trunc;
            lvl_n_reg   <= lev_trunc ? LW'(MAX_LEVELS) : LW'(diff + 1'b1);
            lvl_idx_reg <= '0;
            count_reg   <= '0;
        end
        if (cmd.cnt_step) begin
            count_reg   <= count_reg + CW'(nseg);
            level_reg   <= level_reg + KW'(iv);
            lvl_idx_reg <= lvl_idx_reg + 1'b1;
        end
        if (cmd.emit_prep) begin
            level_reg   <= lev0_reg;
            emitted_reg <= '0;
            seg_reg     <= 1'b0;
            if (int'(count_reg) > MAX_RESULTS) begin
                trunc_reg <= 1'b1;
                total_reg <= CW'(MAX_RESULTS);
            end else begin
                total_reg <= count_reg;
            end
        end
        if (cmd.lvl_next) level_reg <= level_reg + KW'(iv);
        if (cmd.div_pt) begin
            edge_reg <= edge_sel;
            dz_reg   <= (e_d == '0);
        end
        if (cmd.cap_pt) begin
            if (cmd.pt_b) begin
                bx_reg <= PT_W'(px);
                by_reg <= PT_W'(py);
            end else begin
                ax_reg <= PT_W'(px);
                ay_reg <= PT_W'(py);
            end
        end
        if (cmd.out_load) begin
            m_data_reg.start_x   <= ax_reg;
            m_data_reg.start_y   <= ay_reg;
            m_data_reg.end_x     <= bx_reg;
            m_data_reg.end_y     <= by_reg;
            m_data_reg.level_hpa <= level_reg[LEVEL_W-1:0];
            m_data_reg.truncated <= trunc_reg;
            m_data_reg.last      <= sts.last_emit;
            emitted_reg          <= emitted_reg + 1'b1;
            if (sts.seg_more) begin
                seg_reg <= 1'b1;
            end else begin
                seg_reg   <= 1'b0;
                level_reg <= level_reg + KW'(iv);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        sts.div_done  = div_done;
        sts.empty     = k1_reg < k0_reg;
        sts.lvl_done  = lvl_idx_reg == lvl_n_reg;
        sts.cnt_zero  = count_reg == '0;
        sts.nseg_zero = nseg == 2'd0;
        sts.seg_more  = !seg_reg && (nseg == 2'd2);
        sts.last_emit = (emitted_reg + 1'b1) == total_reg;
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

// ===== rtl/ccsg_ctrl.sv =====
// Sequencer: range divisions, segment count pass, then per-segment emission.
// Depends on ccsg_pkg; drives ccsg_datapath through cmd_t / sts_t.
module ccsg_ctrl
    import ccsg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DK0, ST_WK0, ST_DK1, ST_WK1, ST_SETUP, ST_CNT, ST_EPREP,
        ST_ELEV, ST_EDA, ST_WDA, ST_EDB, ST_WDB, ST_EOUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DK0;
                end
            end
            ST_DK0: begin
                cmd.div_k0 = 1'b1;
                state_next = ST_WK0;
            end
            ST_WK0: begin
                if (sts.div_done) begin
                    cmd.cap_k0 = 1'b1;
                    state_next = ST_DK1;
                end
            end
            ST_DK1: begin
                cmd.div_k1 = 1'b1;
                state_next = ST_WK1;
            end
            ST_WK1: begin
                if (sts.div_done) begin
                    cmd.cap_k1 = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (sts.empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.setup  = 1'b1;
                    state_next = ST_CNT;
                end
            end
            ST_CNT: begin
                if (sts.lvl_done) state_next = ST_EPREP;
                else cmd.cnt_step = 1'b1;
            end
            ST_EPREP: begin
                if (sts.cnt_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.emit_prep = 1'b1;
                    state_next    = ST_ELEV;
                end
            end
            ST_ELEV: begin
                if (sts.nseg_zero) cmd.lvl_next = 1'b1;
                else state_next = ST_EDA;
            end
            ST_EDA: begin
                cmd.div_pt = 1'b1;
                state_next = ST_WDA;
            end
            ST_WDA: begin
                if (sts.div_done) begin
                    cmd.cap_pt = 1'b1;
                    state_next = ST_EDB;
                end
            end
            ST_EDB: begin
                cmd.div_pt = 1'b1;
                cmd.pt_b   = 1'b1;
                state_next = ST_WDB;
            end
            ST_WDB: begin
                cmd.pt_b = 1'b1;
                if (sts.div_done) begin
                    cmd.cap_pt = 1'b1;
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.last_emit)     state_next = ST_IDLE;
                    else if (sts.seg_more) state_next = ST_EDA;
                    else                   state_next = ST_ELEV;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
endmodule
